### hw/rtl/ssm_pkg.sv
// Shared types and codes for the swap slot map.
package ssm_pkg;

	localparam int CNT_W  = 11;
	localparam int IDX_W  = 10;
	localparam int ADDR_W = 32;
	localparam int PID_W  = 15;

	localparam logic CMD_SWAP_OUT = 1'b0;
	localparam logic CMD_SWAP_IN  = 1'b1;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND   = 2'd1;
	localparam logic [1:0] ST_ABOVE_BOUND = 2'd2;
	localparam logic [1:0] ST_FULL        = 2'd3;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] page_address;
		logic [PID_W-1:0]  process_id;
		logic              dirty_flag;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] slot_index;
		logic             slot_flag;
	} out_beat_t;

	typedef struct packed {
		logic              used;
		logic [ADDR_W-1:0] page;
		logic [PID_W-1:0]  owner;
		logic              dirty;
	} slot_ent_t;

endpackage

### hw/rtl/ssm_slot_ram.sv
// Slot table storage: one write port, one registered read port.
module ssm_slot_ram
	import ssm_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  slot_ent_t       wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output slot_ent_t       rdata
);

	slot_ent_t mem [DEPTH];
	slot_ent_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/ssm_ctrl.sv
// Sequencer: table clear after reset, linear slot scan, write-back of the hit entry.
module ssm_ctrl
	import ssm_pkg::*;
#(
	parameter int          SLOTS        = 1024,
	parameter logic [31:0] KERNEL_BOUND = 32'h8000_0000,
	parameter int          AW           = 10,
	parameter int          CW           = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] slot_count,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_beat_t         in_beat,
	output logic             res_valid,
	input  logic             res_ready,
	output out_beat_t        res_beat,
	output logic             ram_we,
	output logic [AW-1:0]    ram_waddr,
	output slot_ent_t        ram_wdata,
	output logic             ram_re,
	output logic [AW-1:0]    ram_raddr,
	input  slot_ent_t        ram_rdata
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	in_beat_t      item_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] rd_q;
	logic          chk_vld_q;
	logic          chk_last_q;
	logic [AW-1:0] chk_idx_q;
	out_beat_t     res_q;

	logic [31:0]   cnt32;
	logic [CW-1:0] n_next;
	logic          above;
	logic          issue;
	logic          hit;
	slot_ent_t     fill;

	always_comb begin
		cnt32  = 32'(slot_count);
		n_next = (cnt32 > 32'(SLOTS)) ? CW'(SLOTS) : CW'(cnt32);
		above  = (in_beat.command == CMD_SWAP_OUT) && (in_beat.page_address > KERNEL_BOUND);
		issue  = (state_q == S_SCAN) && (rd_q < n_q);
		if (item_q.command == CMD_SWAP_OUT) begin
			hit = chk_vld_q && !ram_rdata.used;
		end else begin
			hit = chk_vld_q && ram_rdata.used && (ram_rdata.page == item_q.page_address)
				&& (ram_rdata.owner == item_q.process_id);
		end
		if (item_q.command == CMD_SWAP_OUT) begin
			fill.used  = 1'b1;
			fill.page  = item_q.page_address;
			fill.owner = item_q.process_id;
			fill.dirty = item_q.dirty_flag;
		end else begin
			fill      = ram_rdata;
			fill.used = 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_beat  = res_q;

	assign ram_re    = issue;
	assign ram_raddr = rd_q[AW-1:0];
	assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_SCAN) && hit);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : chk_idx_q;
	assign ram_wdata = (state_q == S_CLEAR) ? slot_ent_t'('0) : fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			item_q     <= '0;
			n_q        <= '0;
			rd_q       <= '0;
			chk_vld_q  <= 1'b0;
			chk_last_q <= 1'b0;
			chk_idx_q  <= '0;
			res_q      <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q    <= in_beat;
						n_q       <= n_next;
						rd_q      <= '0;
						chk_vld_q <= 1'b0;
						if (above) begin
							res_q   <= '{status: ST_ABOVE_BOUND, slot_index: '0, slot_flag: 1'b0};
							state_q <= S_DONE;
						end else if (n_next == '0) begin
							res_q.status     <= (in_beat.command == CMD_SWAP_OUT) ?
								ST_FULL : ST_NOT_FOUND;
							res_q.slot_index <= '0;
							res_q.slot_flag  <= 1'b0;
							state_q          <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					chk_vld_q  <= issue;
					chk_idx_q  <= rd_q[AW-1:0];
					chk_last_q <= (rd_q == n_q - CW'(1));
					if (issue) begin
						rd_q <= rd_q + CW'(1);
					end
					if (hit) begin
						res_q.status     <= ST_OK;
						res_q.slot_index <= IDX_W'(chk_idx_q);
						res_q.slot_flag  <= (item_q.command == CMD_SWAP_IN) ?
							ram_rdata.dirty : 1'b0;
						state_q          <= S_DONE;
					end else if (chk_vld_q && chk_last_q) begin
						res_q.status     <= (item_q.command == CMD_SWAP_OUT) ?
							ST_FULL : ST_NOT_FOUND;
						res_q.slot_index <= '0;
						res_q.slot_flag  <= 1'b0;
						state_q          <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/swap_slot_map_top.sv
// Swap slot map top level: config register, sequencer, slot table, output register.
//
//  port group   dir  beat contents
//  in_*         in   command, page_address, process_id, dirty_flag
//  out_*        out  status, slot_index, slot_flag
//  cfg_*        in   slot_count (11 bits), written when cfg_we is high
//
// A swap out or swap in answers once the scan reaches the hit slot, or after all n slots
// when no slot hits, n the clamped slot_count: the scan reads one table entry per cycle
// through the single memory read port.
// A rejected address or a zero count goes straight from idle to the done state without a scan.
// The next beat is taken at the earliest in the cycle after the answer enters the output register.
// After reset the table is cleared one entry per cycle, all SLOTS entries, with in_ready low.
// A result waits in the output register; a new beat is taken while it waits.
module swap_slot_map_top
	import ssm_pkg::*;
#(
	parameter int          SLOTS        = 1024,
	parameter logic [31:0] KERNEL_BOUND = 32'h8000_0000
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_beat_t         in_beat,
	output logic             out_valid,
	input  logic             out_ready,
	output out_beat_t        out_beat,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	logic [CNT_W-1:0] slot_count_q;
	logic             res_valid;
	logic             res_ready;
	out_beat_t        res_beat;
	logic             out_valid_q;
	out_beat_t        out_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	slot_ent_t        ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	slot_ent_t        ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= CNT_W'(1024);
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
		end
	end

	ssm_ctrl #(
		.SLOTS        (SLOTS),
		.KERNEL_BOUND (KERNEL_BOUND),
		.AW           (AW),
		.CW           (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_count (slot_count_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_beat    (in_beat),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_beat   (res_beat),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	ssm_slot_ram #(
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_q       <= res_beat;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat taken while one is in flight");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_beat.status != ST_OK)) |->
			((out_beat.slot_index == '0) && !out_beat.slot_flag))
		else $error("failed result carries index or flag");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> (out_valid_q && (out_q == $past(res_beat))))
		else $error("result not loaded into output register");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ram_we)
		else $error("table written while idle");

endmodule

### sim/swap_slot_map_top_tb.sv
// Testbench for swap_slot_map_top: directed and random swap traffic checked against a slot table model.
module swap_slot_map_top_tb;
	import ssm_pkg::*;

	localparam int          N_SLOTS     = 1024;
	localparam logic [31:0] PAGE_BOUND  = 32'h8000_0000;
	localparam int          STALL_LIMIT = 20000;
	localparam int          MAX_REPORTS = 10;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_beat_t         in_beat   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_beat_t        out_beat;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	slot_ent_t        slot_tbl [N_SLOTS];
	logic [CNT_W-1:0] slot_count_q = 11'd1024;
	out_beat_t        expected_results [$];
	int               mismatches   = 0;
	int               quiet_cycles = 0;
	int               in_idle_pct  = 0;
	int               out_idle_pct = 0;

	swap_slot_map_top #(
		.SLOTS        (N_SLOTS),
		.KERNEL_BOUND (PAGE_BOUND)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_beat  (out_beat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int active_slots();
		return (slot_count_q > N_SLOTS) ? N_SLOTS : int'(slot_count_q);
	endfunction

	// updates the slot table and returns the expected answer
	function automatic out_beat_t predict_slot_op(in_beat_t b);
		out_beat_t res;
		int        n;
		res = '0;
		n = active_slots();
		if (b.command == CMD_SWAP_OUT) begin
			if (b.page_address > PAGE_BOUND) begin
				res.status = ST_ABOVE_BOUND;
				return res;
			end
			for (int i = 0; i < n; i++) begin
				if (!slot_tbl[i].used) begin
					slot_tbl[i].used  = 1'b1;
					slot_tbl[i].page  = b.page_address;
					slot_tbl[i].owner = b.process_id;
					slot_tbl[i].dirty = b.dirty_flag;
					res.status     = ST_OK;
					res.slot_index = IDX_W'(i);
					return res;
				end
			end
			res.status = ST_FULL;
			return res;
		end
		for (int i = 0; i < n; i++) begin
			if (slot_tbl[i].used && slot_tbl[i].page == b.page_address &&
					slot_tbl[i].owner == b.process_id) begin
				slot_tbl[i].used = 1'b0;
				res.status     = ST_OK;
				res.slot_index = IDX_W'(i);
				res.slot_flag  = slot_tbl[i].dirty;
				return res;
			end
		end
		res.status = ST_NOT_FOUND;
		return res;
	endfunction

	function automatic in_beat_t make_request(logic cmd, logic [ADDR_W-1:0] addr,
			logic [PID_W-1:0] pid, logic dirty);
		in_beat_t b;
		b.command      = cmd;
		b.page_address = addr;
		b.process_id   = pid;
		b.dirty_flag   = dirty;
		return b;
	endfunction

	// mostly swap outs and swap ins of stored pages, some noise
	function automatic in_beat_t make_random_request();
		in_beat_t b;
		int       r;
		int       pick;
		int       scan_lim;
		int       used_idx [$];
		r = $urandom_range(99);
		b.command      = CMD_SWAP_IN;
		b.page_address = $urandom();
		b.process_id   = PID_W'($urandom());
		b.dirty_flag   = 1'($urandom_range(1));
		if (r < 45) begin
			b.command = CMD_SWAP_OUT;
			pick = $urandom_range(99);
			if (pick < 10)
				b.page_address = PAGE_BOUND;
			else if (pick < 20)
				b.page_address = $urandom_range(32'hFFFF_FFFF, 32'h8000_0001);
			else if (pick < 40)
				b.page_address = 32'h1000 * $urandom_range(3);
			else
				b.page_address[ADDR_W-1] = 1'b0;
			if ($urandom_range(99) < 30)
				b.process_id = PID_W'($urandom_range(3));
		end else if (r < 85) begin
			scan_lim = ($urandom_range(9) == 0) ? N_SLOTS : active_slots();
			for (int i = 0; i < scan_lim; i++)
				if (slot_tbl[i].used)
					used_idx.push_back(i);
			if (used_idx.size() > 0) begin
				pick = used_idx[$urandom_range(used_idx.size() - 1)];
				b.page_address = slot_tbl[pick].page;
				b.process_id   = slot_tbl[pick].owner;
				if ($urandom_range(19) == 0)
					b.process_id[0] = ~b.process_id[0];
			end
		end
		return b;
	endfunction

	// valid is left high after the beat is taken; drain_results drops it
	task automatic send_request(in_beat_t b);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat  <= b;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_slot_op(b));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_slot_count(logic [CNT_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		slot_count_q  = value;
	endtask

	task automatic test_reset_defaults();
		send_request(make_request(CMD_SWAP_OUT, 32'h0000_0000, 15'h0000, 1'b1));
		send_request(make_request(CMD_SWAP_OUT, PAGE_BOUND, 15'h7FFF, 1'b0));
		send_request(make_request(CMD_SWAP_OUT, PAGE_BOUND + 32'd1, 15'h1234, 1'b1));
		send_request(make_request(CMD_SWAP_OUT, 32'hFFFF_FFFF, 15'h7FFF, 1'b1));
		send_request(make_request(CMD_SWAP_IN, 32'hFFFF_FFFF, 15'h7FFF, 1'b0));
		send_request(make_request(CMD_SWAP_IN, PAGE_BOUND, 15'h7FFE, 1'b1));
		send_request(make_request(CMD_SWAP_IN, PAGE_BOUND, 15'h7FFF, 1'b1));
		send_request(make_request(CMD_SWAP_IN, 32'h0000_0000, 15'h0000, 1'b0));
		send_request(make_request(CMD_SWAP_IN, 32'h0000_0000, 15'h0000, 1'b0));
	endtask

	task automatic test_duplicate_pages();
		set_slot_count(11'd4);
		send_request(make_request(CMD_SWAP_OUT, 32'h0004_5000, 15'd5, 1'b1));
		send_request(make_request(CMD_SWAP_OUT, 32'h0004_5000, 15'd5, 1'b0));
		send_request(make_request(CMD_SWAP_IN, 32'h0004_5000, 15'd5, 1'b0));
		send_request(make_request(CMD_SWAP_IN, 32'h0004_5000, 15'd5, 1'b1));
	endtask

	// full table, hidden slots beyond the count, zero count, clamped count
	task automatic test_count_edges();
		set_slot_count(11'd2);
		send_request(make_request(CMD_SWAP_OUT, 32'h0000_1000, 15'd11, 1'b1));
		send_request(make_request(CMD_SWAP_OUT, 32'h0000_2000, 15'd22, 1'b1));
		send_request(make_request(CMD_SWAP_OUT, 32'h0000_3000, 15'd33, 1'b0));
		set_slot_count(11'd1);
		send_request(make_request(CMD_SWAP_IN, 32'h0000_2000, 15'd22, 1'b0));
		send_request(make_request(CMD_SWAP_OUT, 32'h0000_4000, 15'd44, 1'b1));
		set_slot_count(11'd0);
		send_request(make_request(CMD_SWAP_OUT, 32'h0000_5000, 15'd55, 1'b1));
		send_request(make_request(CMD_SWAP_IN, 32'h0000_1000, 15'd11, 1'b0));
		set_slot_count(11'd2047);
		send_request(make_request(CMD_SWAP_IN, 32'h0000_2000, 15'd22, 1'b0));
		send_request(make_request(CMD_SWAP_IN, 32'h0000_1000, 15'd11, 1'b0));
	endtask

	// runs in bursts, each with a fresh slot count; large counts get short bursts
	task automatic test_random_traffic(int n_items);
		int               sent;
		int               burst;
		int               r;
		logic [CNT_W-1:0] cnt;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 6)
				cnt = 11'd0;
			else if (r < 10)
				cnt = 11'd1;
			else if (r < 14)
				cnt = 11'd2047;
			else if (r < 18)
				cnt = 11'd1024;
			else if (r < 30)
				cnt = CNT_W'($urandom_range(64, 17));
			else
				cnt = CNT_W'($urandom_range(16, 2));
			burst = (cnt >= 11'd1024) ? 4 : 24;
			set_slot_count(cnt);
			for (int k = 0; k < burst; k++)
				send_request(make_random_request());
			sent += burst;
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin : check_results
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result beat: status %0d slot %0d flag %0d",
						out_beat.status, out_beat.slot_index, out_beat.slot_flag);
			end else begin
				want = expected_results.pop_front();
				if (out_beat.status !== want.status ||
						out_beat.slot_index !== want.slot_index ||
						out_beat.slot_flag !== want.slot_flag) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result mismatch: expected status %0d slot %0d flag %0d, got status %0d slot %0d flag %0d",
							want.status, want.slot_index, want.slot_flag,
							out_beat.status, out_beat.slot_index, out_beat.slot_flag);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		foreach (slot_tbl[i])
			slot_tbl[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		in_idle_pct  = 9;
		out_idle_pct = 70;
		test_reset_defaults();
		test_duplicate_pages();
		test_count_edges();
		test_random_traffic(190);

		in_idle_pct  = 70;
		out_idle_pct = 9;
		test_random_traffic(190);

		in_idle_pct  = 0;
		out_idle_pct = 0;
		test_random_traffic(190);

		drain_results();
		repeat (N_SLOTS + 8) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
